### sv/sbl_pkg.sv
// Shared types and codes for the sorted byte list.
// Used by sorted_byte_list; depends on nothing.
`default_nettype none

package sbl_pkg;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam int COUNT_OUT_W = 5;

endpackage

`default_nettype wire

### sv/sorted_byte_list.sv
// Sorted byte list: ascending list of signed bytes held in one synchronous memory.
// Depends on sbl_pkg (status and command codes).
`default_nettype none

// The list holds up to CAPACITY signed bytes in ascending order, duplicates allowed.
// A transaction starts when start is high and busy is low; its single result
// (status and entry_count) appears for exactly one cycle with done high, and the
// receiver cannot stall it. Busy is low again in the cycle that carries done, so
// the next command may be issued there. Entries sit in a memory with one read and
// one write port and a registered read, and each scanning command walks it one
// entry per cycle. An insert into a full list, an insert into an empty list and a
// delete from an empty list finish at once, with done in the cycle after acceptance.
// Any other insert scans from the tail, moving each entry greater than the value up
// by one, and writes the value after the first entry that is not greater, or at the
// head when all are greater. A delete scans from the head for the first equal entry
// and shifts the later entries down over it; it walks every entry whether or not
// the value is found. No clearing pass is needed after reset.
module sorted_byte_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              command,
    input  wire logic signed [7:0] value,
    output logic                   done,
    output logic [2:0]             status,
    output logic [sbl_pkg::COUNT_OUT_W-1:0] entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_HEAD,
        S_DEL_FIND,
        S_DEL_SHIFT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic                   done_reg, done_next;
    sbl_pkg::status_t       status_reg, status_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic signed [7:0]      value_reg, value_next;
    logic signed [7:0]      rdata_reg;

    logic signed [7:0]      mem [CAPACITY];
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic signed [7:0]      wr_data;
    logic                   at_last;

    // Current index is the last held entry
    assign at_last = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    // Sequence the scan and the read-modify-write of the entry memory
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    if (command == sbl_pkg::CMD_INSERT)
                    begin
                        if (fill_reg == CW'(CAPACITY))
                        begin
                            done_next   = 1'b1;
                            status_next = sbl_pkg::ST_FULL;
                        end
                        else if (fill_reg == '0)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                            wr_data     = value;
                            fill_next   = fill_reg + CW'(1);
                            done_next   = 1'b1;
                            status_next = sbl_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            idx_next   = AW'(fill_reg - CW'(1));
                            state_next = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = sbl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DEL_FIND;
                        end
                    end
                end
            end
            S_INS_SCAN:
            begin
                // Shift larger entries up by one; drop the value after the first not larger
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                if (rdata_reg > value_reg)
                begin
                    wr_data = rdata_reg;
                    if (idx_reg == '0)
                        state_next = S_INS_HEAD;
                    else
                        idx_next = idx_reg - AW'(1);
                end
                else
                begin
                    wr_data     = value_reg;
                    fill_next   = fill_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = sbl_pkg::ST_INSERTED;
                    state_next  = S_IDLE;
                end
            end
            S_INS_HEAD:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = value_reg;
                fill_next   = fill_reg + CW'(1);
                done_next   = 1'b1;
                status_next = sbl_pkg::ST_INSERTED;
                state_next  = S_IDLE;
            end
            S_DEL_FIND:
            begin
                if (rdata_reg == value_reg)
                begin
                    if (at_last)
                    begin
                        fill_next   = fill_reg - CW'(1);
                        done_next   = 1'b1;
                        status_next = sbl_pkg::ST_DELETED;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_DEL_SHIFT;
                    end
                end
                else if (at_last)
                begin
                    done_next   = 1'b1;
                    status_next = sbl_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_DEL_SHIFT:
            begin
                // Move each later entry down over the removed one
                wr_en   = 1'b1;
                wr_addr = idx_reg - AW'(1);
                wr_data = rdata_reg;
                if (at_last)
                begin
                    fill_next   = fill_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = sbl_pkg::ST_DELETED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, count and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= sbl_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // Hold scan index and command value
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        value_reg <= value_next;
    end

    // Entry memory: one write, one registered read at the next scan index
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[idx_next];
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = sbl_pkg::COUNT_OUT_W'(fill_reg);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == sbl_pkg::ST_FULL) |-> fill_reg == CW'(CAPACITY))
        else $error("full drop reported on a list that is not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == sbl_pkg::ST_EMPTY) |-> fill_reg == '0)
        else $error("list empty reported on a non-empty list");

    a_count_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fill_reg) |-> done_reg)
        else $error("entry count changed without a result");
`endif

endmodule

`default_nettype wire
